// ===== hdl/b32h_pkg.sv =====
// Shared types and constants for the base32hex stream encoder.
// No dependencies; imported by every module of the encoder.
package b32h_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam int unsigned QUEUE_DEPTH = 2;

    // One classified byte: its character codes and its padding count
    typedef struct packed {
        logic [4:0] code0;
        logic [4:0] code1;
        logic [4:0] code2;
        logic [1:0] n_codes;   // 1..3 alphabet characters
        logic [2:0] n_pads;    // 0..6 pad characters
        logic       eom;
    } t_desc;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // 5-bit code to lowercase extended-hex ASCII, "0-9a-v"
    function automatic logic [7:0] b32h_char(input logic [4:0] code);
        logic [7:0] c;
        c = {3'b000, code};
        if (code < 5'd10) begin
            b32h_char = c + 8'd48;
        end else begin
            b32h_char = c + 8'd87;
        end
    endfunction

endpackage

// ===== hdl/b32h_queue.sv =====
// Two-entry descriptor queue between the front and back of the encoder.
// Depends on b32h_pkg for t_desc and t_q_status.
module b32h_queue
    import b32h_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_desc     i_push_desc,
    input  logic      i_pop,
    output t_desc     o_head,
    output t_q_status o_status
);

    t_desc      r_mem [QUEUE_DEPTH];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_desc;
        end
    end

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = (r_count == 2'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == 2'd0);

endmodule

// ===== hdl/b32h_front.sv =====
// Front of the encoder: tracks group position and leftover bits and
// turns each byte into a descriptor. Depends on b32h_pkg.
module b32h_front
    import b32h_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic [7:0] i_data_byte,
    input  logic      i_end_of_message,
    input  t_q_status i_q_status,
    output logic      o_stall,
    output logic      o_push,
    output t_desc     o_desc
);

    logic [2:0]  r_pos;
    logic [3:0]  r_left;
    logic [2:0]  n_pos;
    logic [3:0]  n_left;

    logic [2:0]  bits_before;
    logic [2:0]  chars_before;
    logic [2:0]  shift;
    logic [11:0] aligned;
    logic [14:0] aligned_x;
    logic [3:0]  bits_after;
    logic        two_chars;
    logic [2:0]  rem;
    logic [1:0]  n_codes;
    logic [3:0]  used;

    // Per-position tables: valid leftover bits and characters already out
    always_comb begin
        unique case (r_pos)
            3'd0:    begin bits_before = 3'd0; chars_before = 3'd0; end
            3'd1:    begin bits_before = 3'd3; chars_before = 3'd1; end
            3'd2:    begin bits_before = 3'd1; chars_before = 3'd3; end
            3'd3:    begin bits_before = 3'd4; chars_before = 3'd4; end
            3'd4:    begin bits_before = 3'd2; chars_before = 3'd6; end
            default: begin bits_before = 3'd0; chars_before = 3'd0; end
        endcase
    end

    // Left-align the valid bits; zero fill gives the partial character
    always_comb begin
        shift      = 3'd4 - bits_before;
        aligned    = {r_left, i_data_byte} << shift;
        aligned_x  = {aligned, 3'b000};
        bits_after = {1'b0, bits_before} + 4'd8;
        two_chars  = (bits_after >= 4'd10);
        rem        = two_chars ? 3'(bits_after - 4'd10) : 3'(bits_after - 4'd5);
        n_codes    = (two_chars ? 2'd2 : 2'd1)
                   + {1'b0, (i_end_of_message && rem != 3'd0)};
        used       = {1'b0, chars_before} + {2'b00, n_codes};
    end

    // Descriptor for the queue
    always_comb begin
        o_desc.code0   = aligned_x[14:10];
        o_desc.code1   = aligned_x[9:5];
        o_desc.code2   = aligned_x[4:0];
        o_desc.n_codes = n_codes;
        o_desc.n_pads  = i_end_of_message ? 3'(4'd8 - used) : 3'd0;
        o_desc.eom     = i_end_of_message;
    end

    // Next group state
    always_comb begin
        if (i_end_of_message) begin
            n_pos  = 3'd0;
            n_left = 4'd0;
        end else begin
            n_pos  = (r_pos == 3'd4) ? 3'd0 : r_pos + 3'd1;
            n_left = i_data_byte[3:0] & 4'((5'd1 << rem) - 5'd1);
        end
    end

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 3'd0;
            r_left <= 4'd0;
        end else if (o_push) begin
            r_pos  <= n_pos;
            r_left <= n_left;
        end
    end

endmodule

// ===== hdl/b32h_back.sv =====
// Back of the encoder: walks each descriptor one character per cycle
// into the output register while i_stall is low. Depends on b32h_pkg.
module b32h_back
    import b32h_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_desc      i_head,
    input  t_q_status  i_q_status,
    input  logic       i_stall,
    output logic       o_pop,
    output logic       o_valid,
    output logic [7:0] o_out_char,
    output logic       o_last_char
);

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic [2:0] n_idx;
    logic [7:0] n_char;
    logic [3:0] total;
    logic       desc_done;
    logic       load;

    // Character select for the current index
    always_comb begin
        total     = {2'b00, i_head.n_codes} + {1'b0, i_head.n_pads};
        desc_done = ({1'b0, r_idx} + 4'd1 == total);
        case (r_idx)
            3'd0:    n_char = b32h_char(i_head.code0);
            3'd1:    n_char = (i_head.n_codes > 2'd1) ? b32h_char(i_head.code1) : PAD_CHAR;
            3'd2:    n_char = (i_head.n_codes > 2'd2) ? b32h_char(i_head.code2) : PAD_CHAR;
            default: n_char = PAD_CHAR;
        endcase
        load  = !i_q_status.empty && (!r_valid || !i_stall);
        o_pop = load && desc_done;
        n_idx = desc_done ? 3'd0 : r_idx + 3'd1;
    end

    // Index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= n_idx;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= n_char;
            r_last <= desc_done && i_head.eom;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

endmodule

// ===== hdl/base32hex_stream_encoder.sv =====
// Channel  Dir  Handshake          Payload
// input    in   i_valid / o_stall  i_data_byte[7:0], i_end_of_message
// output   out  o_valid / i_stall  o_out_char[7:0], o_last_char
//
// Each byte yields one to eight characters, one character per cycle from
// the back end while i_stall is low; a final byte at group start yields
// eight. The front takes a byte per cycle while the two-entry queue has
// room. Reset is synchronous, active low, and returns to the start of a
// group. An output stall can fill the queue and then stall the input.
//
// Top level of the base32hex stream encoder; depends on b32h_pkg,
// b32h_front, b32h_queue and b32h_back.
module base32hex_stream_encoder
    import b32h_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_message,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_last_char
);

    t_desc     push_desc;
    t_desc     head;
    t_q_status q_status;
    logic      push;
    logic      pop;

    b32h_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .i_q_status       (q_status),
        .o_stall          (o_stall),
        .o_push           (push),
        .o_desc           (push_desc)
    );

    b32h_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_desc (push_desc),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (q_status)
    );

    b32h_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_status  (q_status),
        .i_stall     (i_stall),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for base32hex_stream_encoder: directed table plus random messages.
// Checks every output character against the in-bench encoder model or a typed directed row.
// Depends on b32h_pkg and the base32hex_stream_encoder RTL.
module tb_top
    import b32h_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 2000;   // cycles with no beat on either side
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 450;
    localparam int MAX_REPORTS  = 50;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_char_beat;

    // Directed row: n_typed == 0 means the expectation comes from the encoder model
    typedef struct {
        logic [7:0]  data;
        logic        eom;
        int          n_typed;
        logic [63:0] typed;
    } t_row;

    typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PATTERN, RX_HEAVY} t_rx_mode;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_end_of_message = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_out_char;
    logic       o_last_char;

    // Encoder model state
    logic [2:0] enc_pos = 3'd0;
    logic [3:0] enc_rem = 4'd0;
    t_char_beat exp_chars[$];

    int         mismatches = 0;
    int         burst_left = 0;
    int         idle_cycles = 0;
    bit         rx_quiet = 1'b0;
    t_rx_mode   rx_mode = RX_FREE;
    int         mode_left = 0;
    logic [7:0] stall_pat = 8'b1100_1010;
    t_char_beat got_want;

    t_row dir_rows[25] = '{
        '{8'h00, 1'b1, 8, "00======"},
        '{8'hFF, 1'b1, 8, "vs======"},
        '{8'h7F, 1'b1, 8, "fs======"},
        '{8'hA5, 1'b0, 0, 64'h0},
        '{8'h5A, 1'b1, 0, 64'h0},
        '{8'h55, 1'b0, 0, 64'h0},
        '{8'hAA, 1'b1, 0, 64'h0},
        '{8'h01, 1'b0, 0, 64'h0},
        '{8'h02, 1'b0, 0, 64'h0},
        '{8'h03, 1'b1, 0, 64'h0},
        '{8'hFF, 1'b0, 0, 64'h0},
        '{8'hFF, 1'b0, 0, 64'h0},
        '{8'hFF, 1'b0, 0, 64'h0},
        '{8'hFF, 1'b1, 0, 64'h0},
        // full group ending the message: no partial char, no padding
        '{8'h00, 1'b0, 0, 64'h0},
        '{8'h44, 1'b0, 0, 64'h0},
        '{8'h32, 1'b0, 0, 64'h0},
        '{8'h14, 1'b0, 0, 64'h0},
        '{8'hC7, 1'b1, 2, "67"},
        // message crossing into a second group
        '{8'hFF, 1'b0, 0, 64'h0},
        '{8'hFF, 1'b0, 0, 64'h0},
        '{8'hFF, 1'b0, 0, 64'h0},
        '{8'hFF, 1'b0, 0, 64'h0},
        '{8'hFF, 1'b0, 0, 64'h0},
        '{8'h80, 1'b1, 8, "g0======"}
    };

    base32hex_stream_encoder uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_char       (o_out_char),
        .o_last_char      (o_last_char)
    );

    always #2 i_clk = ~i_clk;

    // 5-bit code to lowercase extended-hex ASCII
    function automatic logic [7:0] b32_ascii(input logic [4:0] code);
        logic [7:0] wide;
        wide = {3'b000, code};
        return (code < 5'd10) ? wide + 8'h30 : wide - 8'd10 + 8'h61;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_REPORTS) begin
            $display("mismatch @%0t: %s", $realtime, what);
        end
        mismatches++;
    endtask

    // Advance the encoder model by one byte; queue its chars when keep is set
    task automatic encode_byte(input logic [7:0] b, input logic e, input bit keep);
        int          held;
        int          done;
        logic [11:0] acc;
        t_char_beat  chars[$];
        t_char_beat  c;
        held = (int'(enc_pos) * 8) % 5 + 8;
        done = (int'(enc_pos) * 8) / 5;
        acc  = {enc_rem, b};
        c.last = 1'b0;
        while (held >= 5) begin
            held -= 5;
            c.ch = b32_ascii(5'((acc >> held) & 12'h1F));
            chars.push_back(c);
            done++;
        end
        if (e) begin
            // zero-fill the tail, then pad the group out to 8 chars
            if (held > 0) begin
                c.ch = b32_ascii(5'((acc << (5 - held)) & 12'h1F));
                chars.push_back(c);
                done++;
            end
            while (done < 8) begin
                c.ch = PAD_CHAR;
                chars.push_back(c);
                done++;
            end
            chars[chars.size() - 1].last = 1'b1;
            enc_pos = 3'd0;
            enc_rem = 4'd0;
        end else begin
            enc_pos = (enc_pos == 3'd4) ? 3'd0 : enc_pos + 3'd1;
            enc_rem = 4'(acc & ((12'd1 << held) - 12'd1));
        end
        if (keep) begin
            foreach (chars[k]) exp_chars.push_back(chars[k]);
        end
    endtask

    // Send one byte beat, with bursty idling in front; called right after a rising edge
    task automatic send_byte(input logic [7:0] b, input logic e,
                             input int n_typed, input logic [63:0] typed);
        int         gap;
        t_char_beat c;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
        end
        burst_left--;
        i_valid          <= 1'b1;
        i_data_byte      <= b;
        i_end_of_message <= e;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        encode_byte(b, e, n_typed == 0);
        for (int k = 0; k < n_typed; k++) begin
            c.ch   = typed[8 * (n_typed - 1 - k) +: 8];
            c.last = e && (k == n_typed - 1);
            exp_chars.push_back(c);
        end
    endtask

    // Receiver stall pattern: switches between free, random, rotating and heavy stalls
    always @(posedge i_clk) begin
        if (!i_rst_n || rx_quiet) begin
            i_stall <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= t_rx_mode'($urandom_range(0, 3));
                mode_left <= $urandom_range(20, 120);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_FREE: begin
                    i_stall <= 1'b0;
                end
                RX_RANDOM: begin
                    i_stall <= ($urandom_range(0, 99) < 40);
                end
                RX_PATTERN: begin
                    stall_pat <= {stall_pat[6:0], stall_pat[7]};
                    i_stall   <= stall_pat[7];
                end
                default: begin
                    i_stall <= ($urandom_range(0, 15) != 0);
                end
            endcase
        end
    end

    // Output checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (exp_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char 0x%h last=%b",
                                          o_out_char, o_last_char));
            end else begin
                got_want = exp_chars.pop_front();
                if (o_out_char !== got_want.ch) begin
                    report_mismatch($sformatf("out_char 0x%h, want 0x%h",
                                              o_out_char, got_want.ch));
                end
                if (o_last_char !== got_want.last) begin
                    report_mismatch($sformatf("last_char %b, want %b (char 0x%h)",
                                              o_last_char, got_want.last, got_want.ch));
                end
            end
        end
    end

    // Watchdog: too long without a beat on either side ends the run
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
                $display("[base32hex_stream_encoder] ERROR");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin : stim
        int         rand_items;
        int         msg_len;
        int         pick;
        logic [7:0] b;
        rand_items = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            send_byte(dir_rows[r].data, dir_rows[r].eom,
                      dir_rows[r].n_typed, dir_rows[r].typed);
        end

        // Random messages, mostly short, a few spanning several groups
        while (rand_items < RANDOM_ITEMS) begin
            msg_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 7)
                                                 : $urandom_range(8, 24);
            for (int n = 0; n < msg_len; n++) begin
                pick = $urandom_range(0, 7);
                b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
                send_byte(b, n == msg_len - 1, 0, 64'h0);
                rand_items++;
            end
        end

        i_valid  <= 1'b0;
        rx_quiet = 1'b1;
        while (exp_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && exp_chars.size() == 0) begin
            $display("[base32hex_stream_encoder] OK");
        end else begin
            $display("[base32hex_stream_encoder] ERROR");
        end
        $finish;
    end

endmodule
